### sv/geodetic_to_enu_core_assert.svh
// assertion macros for the geodetic to enu core checker
// depends on nothing; included by the checker file only
`ifndef GEODETIC_TO_ENU_CORE_ASSERT_SVH
`define GEODETIC_TO_ENU_CORE_ASSERT_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define G2E_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define G2E_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/g2e_pkg.sv
// shared types, constants and fixed-point helpers for the geodetic to enu core
// no dependencies; used by the core
package g2e_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int SQRT_STEPS   = 31;
   localparam int DIV_STEPS    = 33;

   // cordic start value and arctangent table in phase units (full turn = 2^32)
   localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
   localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
   };

   // divide by 45: 2^20 = 45 * 23301 + 31, then reciprocal of 45 over 2^30
   localparam logic [14:0] PH_QA_MUL = 15'd23301;
   localparam logic [4:0]  PH_R_MUL  = 5'd31;
   localparam logic [24:0] PH_RECIP  = 25'd23860930;

   // ellipsoid constants
   localparam logic [32:0] E2_Q40   = 33'd7360548640;
   localparam logic [24:0] E2_Q32   = 25'd28752143;
   localparam logic [62:0] SEMI_Q30 = 63'd6378137000 << 30;
   localparam logic signed [39:0] OUT_LIMIT = 40'sd16000000000;
   localparam logic signed [33:0] TRIG_ONE  = 34'sd1073741824;

   typedef enum logic [1:0] {
      CSR_REF_LAT = 2'd0,
      CSR_REF_LON = 2'd1,
      CSR_REF_ALT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               valid;
      logic               is_ref;
      logic signed [27:0] alt;
   } side_type;

   typedef struct packed {
      logic signed [31:0] sl;
      logic signed [31:0] cl;
      logic signed [31:0] so;
      logic signed [31:0] co;
   } trig_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } cordic_type;

   // round(a * b / 2^30), half away from zero
   function automatic logic signed [39:0] mq(input logic signed [39:0] a,
                                             input logic signed [31:0] b);
      logic [39:0] ua;
      logic [31:0] ub;
      logic [71:0] prod;
      logic [39:0] mag;
      ua   = a[39] ? 40'(-a) : 40'(a);
      ub   = b[31] ? 32'(-b) : 32'(b);
      prod = ({32'd0, ua} * {40'd0, ub}) + 72'd536870912;
      mag  = prod[69:30];
      return (a[39] ^ b[31]) ? -$signed(mag) : $signed(mag);
   endfunction

   // clamp a cordic output to plus or minus one
   function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
      if (v > TRIG_ONE) return 32'(TRIG_ONE);
      if (v < -TRIG_ONE) return 32'(-TRIG_ONE);
      return 32'(v);
   endfunction

   // saturate to the output range
   function automatic logic signed [34:0] sat_out(input logic signed [39:0] v);
      if (v > OUT_LIMIT) return 35'(OUT_LIMIT);
      if (v < -OUT_LIMIT) return 35'(-OUT_LIMIT);
      return 35'(v);
   endfunction

endpackage

### sv/geodetic_to_enu_core.sv
// pipelined wgs84 geodetic to east-north-up converter
// depends on g2e_pkg
//
//  channel  ports                          handshake
//  request  req_target_*                   start, busy
//  result   rsp_east/north/up_mm           rsp_valid strobe, one cycle
//  config   csr_index, csr_data            csr_valid, csr_ready (always high)
//
// one position enters per cycle while busy is low; the pipeline holds the
// 30-stage cordic, the 31-stage square root and the 33-stage restoring divider,
// one step per stage.
// after reset and after each register write the reference position runs through
// the same pipeline once; busy is high until it lands.
// reset is synchronous; it clears valid bits and the registers and sets the refresh flag.
// the result side never stalls, so the pipeline advances every cycle.
module geodetic_to_enu_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_target_latitude,
   input  logic signed [32:0] req_target_longitude,
   input  logic signed [27:0] req_target_altitude,
   output logic               rsp_valid,
   output logic signed [34:0] rsp_east_mm,
   output logic signed [34:0] rsp_north_mm,
   output logic signed [34:0] rsp_up_mm,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [32:0]        csr_data
);

   localparam int NC = g2e_pkg::CORDIC_STEPS;
   localparam int NS = g2e_pkg::SQRT_STEPS;
   localparam int ND = g2e_pkg::DIV_STEPS;

   // configuration registers and refresh control
   logic signed [31:0] ref_lat_ff;
   logic signed [32:0] ref_lon_ff;
   logic signed [27:0] ref_alt_ff;
   logic               dirty_ff;
   logic [7:0]         ref_cnt_ff, ref_cnt_in;
   logic               csr_wr, take, retire;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;
   assign busy      = dirty_ff | (ref_cnt_ff != 8'd0);
   assign take      = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_lat_ff <= '0;
         ref_lon_ff <= '0;
         ref_alt_ff <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            g2e_pkg::CSR_REF_LAT: ref_lat_ff <= csr_data[31:0];
            g2e_pkg::CSR_REF_LON: ref_lon_ff <= csr_data;
            g2e_pkg::CSR_REF_ALT: ref_alt_ff <= csr_data[27:0];
            default: ;
         endcase
      end
   end

   // reference refresh: flag set by a write, cleared when its item is injected
   assign ref_cnt_in = ref_cnt_ff + {7'd0, dirty_ff} - {7'd0, retire};

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff   <= 1'b1;
         ref_cnt_ff <= '0;
      end else begin
         dirty_ff   <= csr_wr;
         ref_cnt_ff <= ref_cnt_in;
      end
   end

   // input stage: target on transfer, reference while refreshing
   g2e_pkg::side_type  side0_ff, side1_ff, side2_ff;
   logic signed [32:0] ang0_ff [0:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         side0_ff <= '0;
         side1_ff <= '0;
         side2_ff <= '0;
      end else begin
         side0_ff.valid  <= take | dirty_ff;
         side0_ff.is_ref <= dirty_ff;
         side0_ff.alt    <= dirty_ff ? ref_alt_ff : req_target_altitude;
         side1_ff        <= side0_ff;
         side2_ff        <= side1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ang0_ff[0] <= dirty_ff ? 33'(ref_lat_ff) : 33'(req_target_latitude);
      ang0_ff[1] <= dirty_ff ? ref_lon_ff : req_target_longitude;
   end

   // cordic lanes: lane 0 latitude, lane 1 longitude
   g2e_pkg::cordic_type cord_ff [0:1][0:NC];
   logic                flip_ff [0:1][0:NC];
   g2e_pkg::side_type   side_c_ff [0:NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         side_c_ff[0] <= '0;
      end else begin
         side_c_ff[0] <= side2_ff;
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_lane
      logic [32:0] mag;
      logic [37:0] nsum;
      logic [32:0] qa_in;
      logic [23:0] r_in;
      logic [32:0] ph1_qa_ff;
      logic [23:0] ph1_r_ff;
      logic        ph1_neg_ff;
      logic [48:0] rprod;
      logic [32:0] q_in;
      logic [32:0] ph2_q_ff;
      logic        ph2_neg_ff;
      logic [31:0] phase;
      logic signed [33:0] ps;

      // angle times 32, rounded, split as a * 2^20 + b for the divide by 45
      assign mag   = ang0_ff[g][32] ? 33'(-ang0_ff[g]) : 33'(ang0_ff[g]);
      assign nsum  = {mag, 5'd0} + 38'd22;
      assign qa_in = {15'd0, nsum[37:20]} * {18'd0, g2e_pkg::PH_QA_MUL};
      assign r_in  = 24'({6'd0, nsum[37:20]} * {19'd0, g2e_pkg::PH_R_MUL})
                     + {4'd0, nsum[19:0]};

      always_ff @(posedge clock) begin
         ph1_qa_ff  <= qa_in;
         ph1_r_ff   <= r_in;
         ph1_neg_ff <= ang0_ff[g][32];
      end

      // remainder part through the reciprocal
      assign rprod = {25'd0, ph1_r_ff} * {24'd0, g2e_pkg::PH_RECIP};
      assign q_in  = ph1_qa_ff + {14'd0, rprod[48:30]};

      always_ff @(posedge clock) begin
         ph2_q_ff   <= q_in;
         ph2_neg_ff <= ph1_neg_ff;
      end

      // phase, then fold into plus or minus a quarter turn
      assign phase = ph2_neg_ff ? 32'(-ph2_q_ff[31:0]) : ph2_q_ff[31:0];
      assign ps    = {{2{phase[31]}}, phase};

      always_ff @(posedge clock) begin
         cord_ff[g][0].x <= g2e_pkg::CORDIC_K;
         cord_ff[g][0].y <= '0;
         if (ps > g2e_pkg::TRIG_ONE) begin
            cord_ff[g][0].z <= ps - 34'sd2147483648;
            flip_ff[g][0]   <= 1'b1;
         end else if (ps < -g2e_pkg::TRIG_ONE) begin
            cord_ff[g][0].z <= ps + 34'sd2147483648;
            flip_ff[g][0]   <= 1'b1;
         end else begin
            cord_ff[g][0].z <= ps;
            flip_ff[g][0]   <= 1'b0;
         end
      end

      // one rotation per stage
      for (genvar i = 0; i < NC; i++) begin : g_rot
         logic signed [33:0] sx, sy, at;
         assign sx = $signed(cord_ff[g][i].y) >>> i;
         assign sy = $signed(cord_ff[g][i].x) >>> i;
         assign at = $signed({2'b00, g2e_pkg::ATAN_TAB[i]});

         always_ff @(posedge clock) begin
            flip_ff[g][i+1] <= flip_ff[g][i];
            if (!cord_ff[g][i].z[33]) begin
               cord_ff[g][i+1].x <= cord_ff[g][i].x - sx;
               cord_ff[g][i+1].y <= cord_ff[g][i].y + sy;
               cord_ff[g][i+1].z <= cord_ff[g][i].z - at;
            end else begin
               cord_ff[g][i+1].x <= cord_ff[g][i].x + sx;
               cord_ff[g][i+1].y <= cord_ff[g][i].y - sy;
               cord_ff[g][i+1].z <= cord_ff[g][i].z + at;
            end
         end
      end
   end

   for (genvar i = 0; i < NC; i++) begin : g_side_c
      always_ff @(posedge clock) begin
         if (reset) begin
            side_c_ff[i+1] <= '0;
         end else begin
            side_c_ff[i+1] <= side_c_ff[i];
         end
      end
   end

   // trig values, sin squared of latitude, then the square root operand
   g2e_pkg::side_type side4_ff, side5_ff;
   g2e_pkg::trig_type trig4_ff, trig5_ff;
   logic signed [33:0] lat_x, lat_y, lon_x, lon_y;
   logic signed [39:0] s2_full;
   logic [30:0]        s2_ff;
   logic [63:0]        e2_prod;

   assign lat_x = flip_ff[0][NC] ? -cord_ff[0][NC].x : cord_ff[0][NC].x;
   assign lat_y = flip_ff[0][NC] ? -cord_ff[0][NC].y : cord_ff[0][NC].y;
   assign lon_x = flip_ff[1][NC] ? -cord_ff[1][NC].x : cord_ff[1][NC].x;
   assign lon_y = flip_ff[1][NC] ? -cord_ff[1][NC].y : cord_ff[1][NC].y;
   assign s2_full = g2e_pkg::mq(40'(trig4_ff.sl), trig4_ff.sl);
   assign e2_prod = ({33'd0, s2_ff} * {31'd0, g2e_pkg::E2_Q40}) + 64'd512;

   always_ff @(posedge clock) begin
      if (reset) begin
         side4_ff <= '0;
         side5_ff <= '0;
      end else begin
         side4_ff <= side_c_ff[NC];
         side5_ff <= side4_ff;
      end
   end

   always_ff @(posedge clock) begin
      trig4_ff.sl <= g2e_pkg::clamp_one(lat_y);
      trig4_ff.cl <= g2e_pkg::clamp_one(lat_x);
      trig4_ff.so <= g2e_pkg::clamp_one(lon_y);
      trig4_ff.co <= g2e_pkg::clamp_one(lon_x);
      s2_ff       <= s2_full[30:0];
      trig5_ff    <= trig4_ff;
   end

   // square root, one result bit per stage
   logic [61:0]       sq_w_ff [0:NS];
   logic [61:0]       sq_r_ff [0:NS];
   g2e_pkg::side_type side_s_ff [0:NS];
   g2e_pkg::trig_type trig_s_ff [0:NS];

   always_ff @(posedge clock) begin
      sq_w_ff[0]   <= (62'd1 << 60) - {8'd0, e2_prod[63:10]};
      sq_r_ff[0]   <= '0;
      trig_s_ff[0] <= trig5_ff;
      if (reset) begin
         side_s_ff[0] <= '0;
      end else begin
         side_s_ff[0] <= side5_ff;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
      logic [61:0] trial;
      assign trial = sq_r_ff[k] + BIT;

      always_ff @(posedge clock) begin
         trig_s_ff[k+1] <= trig_s_ff[k];
         if (sq_w_ff[k] >= trial) begin
            sq_w_ff[k+1] <= sq_w_ff[k] - trial;
            sq_r_ff[k+1] <= (sq_r_ff[k] >> 1) + BIT;
         end else begin
            sq_w_ff[k+1] <= sq_w_ff[k];
            sq_r_ff[k+1] <= sq_r_ff[k] >> 1;
         end
         if (reset) begin
            side_s_ff[k+1] <= '0;
         end else begin
            side_s_ff[k+1] <= side_s_ff[k];
         end
      end
   end

   // prime-vertical radius by restoring division, one quotient bit per stage
   logic [30:0]       dv_rem_ff [0:ND];
   logic [32:0]       dv_q_ff   [0:ND];
   logic [32:0]       dv_lo_ff  [0:ND];
   logic [30:0]       dv_u_ff   [0:ND];
   g2e_pkg::side_type side_d_ff [0:ND];
   g2e_pkg::trig_type trig_d_ff [0:ND];
   logic [30:0]       u_fix;
   logic [62:0]       numer;

   assign u_fix = (sq_r_ff[NS][30:0] == 31'd0) ? 31'd1 : sq_r_ff[NS][30:0];
   assign numer = g2e_pkg::SEMI_Q30 + {33'd0, u_fix[30:1]};

   always_ff @(posedge clock) begin
      dv_rem_ff[0] <= {1'b0, numer[62:33]};
      dv_q_ff[0]   <= '0;
      dv_lo_ff[0]  <= numer[32:0];
      dv_u_ff[0]   <= u_fix;
      trig_d_ff[0] <= trig_s_ff[NS];
      if (reset) begin
         side_d_ff[0] <= '0;
      end else begin
         side_d_ff[0] <= side_s_ff[NS];
      end
   end

   for (genvar j = 0; j < ND; j++) begin : g_div
      localparam int BP = ND - 1 - j;
      logic [31:0] sh;
      logic [31:0] diff;
      assign sh   = {dv_rem_ff[j], dv_lo_ff[j][BP]};
      assign diff = sh - {1'b0, dv_u_ff[j]};

      always_ff @(posedge clock) begin
         dv_lo_ff[j+1]  <= dv_lo_ff[j];
         dv_u_ff[j+1]   <= dv_u_ff[j];
         trig_d_ff[j+1] <= trig_d_ff[j];
         if (sh >= {1'b0, dv_u_ff[j]}) begin
            dv_rem_ff[j+1]   <= diff[30:0];
            dv_q_ff[j+1]     <= dv_q_ff[j] | (33'd1 << BP);
         end else begin
            dv_rem_ff[j+1]   <= sh[30:0];
            dv_q_ff[j+1]     <= dv_q_ff[j];
         end
         if (reset) begin
            side_d_ff[j+1] <= '0;
         end else begin
            side_d_ff[j+1] <= side_d_ff[j];
         end
      end
   end

   // earth-centred coordinates
   g2e_pkg::side_type  side_p1_ff, side_p2_ff, side_p3_ff;
   g2e_pkg::trig_type  trig_p1_ff, trig_p2_ff, trig_p3_ff;
   logic [32:0]        n_p1_ff;
   logic signed [39:0] nh_p1_ff, rh_p2_ff, zz_p2_ff;
   logic [25:0]        ncorr_p1_ff;
   logic [57:0]        ncorr_prod;
   logic signed [39:0] x_p3_ff, y_p3_ff, z_p3_ff;

   assign ncorr_prod = ({25'd0, dv_q_ff[ND]} * {33'd0, g2e_pkg::E2_Q32})
                       + (58'd1 << 31);

   always_ff @(posedge clock) begin
      if (reset) begin
         side_p1_ff <= '0;
         side_p2_ff <= '0;
         side_p3_ff <= '0;
      end else begin
         side_p1_ff <= side_d_ff[ND];
         side_p2_ff <= side_p1_ff;
         side_p3_ff <= side_p2_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_p1_ff     <= dv_q_ff[ND];
      nh_p1_ff    <= $signed({7'd0, dv_q_ff[ND]}) + 40'(side_d_ff[ND].alt);
      ncorr_p1_ff <= ncorr_prod[57:32];
      trig_p1_ff  <= trig_d_ff[ND];
      rh_p2_ff    <= g2e_pkg::mq(nh_p1_ff, trig_p1_ff.cl);
      zz_p2_ff    <= $signed({7'd0, n_p1_ff}) - $signed({14'd0, ncorr_p1_ff})
                     + 40'(side_p1_ff.alt);
      trig_p2_ff  <= trig_p1_ff;
      x_p3_ff     <= g2e_pkg::mq(rh_p2_ff, trig_p2_ff.co);
      y_p3_ff     <= g2e_pkg::mq(rh_p2_ff, trig_p2_ff.so);
      z_p3_ff     <= g2e_pkg::mq(zz_p2_ff, trig_p2_ff.sl);
      trig_p3_ff  <= trig_p2_ff;
   end

   // reference position lands here
   logic signed [39:0] rx_ff, ry_ff, rz_ff;
   g2e_pkg::trig_type  rtrig_ff;

   assign retire = side_p3_ff.valid & side_p3_ff.is_ref;

   always_ff @(posedge clock) begin
      if (retire) begin
         rx_ff    <= x_p3_ff;
         ry_ff    <= y_p3_ff;
         rz_ff    <= z_p3_ff;
         rtrig_ff <= trig_p3_ff;
      end
   end

   // rotation into the local frame
   logic               b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff, b5_valid_ff;
   logic signed [39:0] dx_ff, dy_ff, dz_b1_ff;
   logic signed [39:0] a1_ff, a2_ff, e1_ff, e2_ff, dz_b2_ff;
   logic signed [39:0] t_ff, east_b3_ff, dz_b3_ff;
   logic signed [39:0] n1_ff, n2_ff, u1_ff, u2_ff, east_b4_ff;
   logic signed [34:0] east_ff, north_ff, up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
         b5_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= side_p3_ff.valid & ~side_p3_ff.is_ref;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
         b5_valid_ff <= b4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff      <= x_p3_ff - rx_ff;
      dy_ff      <= y_p3_ff - ry_ff;
      dz_b1_ff   <= z_p3_ff - rz_ff;
      a1_ff      <= g2e_pkg::mq(dx_ff, rtrig_ff.co);
      a2_ff      <= g2e_pkg::mq(dy_ff, rtrig_ff.so);
      e1_ff      <= g2e_pkg::mq(dy_ff, rtrig_ff.co);
      e2_ff      <= g2e_pkg::mq(dx_ff, rtrig_ff.so);
      dz_b2_ff   <= dz_b1_ff;
      t_ff       <= a1_ff + a2_ff;
      east_b3_ff <= e1_ff - e2_ff;
      dz_b3_ff   <= dz_b2_ff;
      n1_ff      <= g2e_pkg::mq(dz_b3_ff, rtrig_ff.cl);
      n2_ff      <= g2e_pkg::mq(t_ff, rtrig_ff.sl);
      u1_ff      <= g2e_pkg::mq(t_ff, rtrig_ff.cl);
      u2_ff      <= g2e_pkg::mq(dz_b3_ff, rtrig_ff.sl);
      east_b4_ff <= east_b3_ff;
      east_ff    <= g2e_pkg::sat_out(east_b4_ff);
      north_ff   <= g2e_pkg::sat_out(n1_ff - n2_ff);
      up_ff      <= g2e_pkg::sat_out(u1_ff + u2_ff);
   end

   assign rsp_valid    = b5_valid_ff;
   assign rsp_east_mm  = east_ff;
   assign rsp_north_mm = north_ff;
   assign rsp_up_mm    = up_ff;

endmodule

### sv/g2e_checker.sv
// port-level checks for the geodetic to enu core, bound to the top level
// depends on geodetic_to_enu_core_assert.svh and geodetic_to_enu_core
`include "geodetic_to_enu_core_assert.svh"

module g2e_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [34:0] rsp_east_mm,
   input logic signed [34:0] rsp_north_mm,
   input logic signed [34:0] rsp_up_mm,
   input logic               csr_valid,
   input logic               csr_ready
);

   // east and up results stay inside the saturation bounds
   `G2E_ASSERT_SAME(a_east_range, clock, reset, rsp_valid, (rsp_east_mm >= -35'sd16000000000 && rsp_east_mm <= 35'sd16000000000), "east out of range")
   `G2E_ASSERT_SAME(a_up_range, clock, reset, rsp_valid, (rsp_up_mm >= -35'sd16000000000 && rsp_up_mm <= 35'sd16000000000), "up out of range")

   // the reference is rebuilt after reset and after every register transfer
   `G2E_ASSERT_SAME(a_busy_after_reset, clock, reset, $fell(reset), busy, "not busy after reset")
   `G2E_ASSERT_NEXT(a_busy_after_write, clock, reset, (csr_valid && csr_ready), busy, "not busy after write")

endmodule

bind geodetic_to_enu_core g2e_checker u_g2e_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_east_mm  (rsp_east_mm),
   .rsp_north_mm (rsp_north_mm),
   .rsp_up_mm    (rsp_up_mm),
   .csr_valid    (csr_valid),
   .csr_ready    (csr_ready)
);
